// File: rtl/core/seven_segment_scan_controller_defines.svh
// ----------------------------------------------------------------------------
// Seven-segment scan controller assertion macros
// Shared concurrent assertion wrappers, clocked on clock, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_CONTROLLER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

`define SSSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define SSSC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`else

`define SSSC_ASSERT(label, prop, msg)

`define SSSC_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// File: rtl/core/sssc_pkg.sv
// ----------------------------------------------------------------------------
// sssc_pkg
// Widths, codes, glyph table and shared types of the scan controller.
// ----------------------------------------------------------------------------
package sssc_pkg;

   localparam int FUNC_W              = 2;
   localparam int VALUE_W             = 32;
   localparam int SEG_W               = 8;
   localparam int SEL_W               = 4;
   localparam int DIGIT_W             = 4;
   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int CONV_STEPS          = VALUE_W;
   localparam int COUNT_W             = $clog2(CONV_STEPS);
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int DOT_DIV_W           = 8;

   localparam logic REG_DOTS_ENABLE = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK = 2'd0,
      FUNC_DEC  = 2'd1,
      FUNC_HEX  = 2'd2,
      FUNC_BIN  = 2'd3
   } func_type;

   typedef struct packed {
      logic busy;
      logic done;
   } conv_status_type;

   function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'h0: seg = 8'h3F;
         4'h1: seg = 8'h06;
         4'h2: seg = 8'h5B;
         4'h3: seg = 8'h4F;
         4'h4: seg = 8'h66;
         4'h5: seg = 8'h6D;
         4'h6: seg = 8'h7D;
         4'h7: seg = 8'h07;
         4'h8: seg = 8'h7F;
         4'h9: seg = 8'h6F;
         4'hA: seg = 8'h77;
         4'hB: seg = 8'h7C;
         4'hC: seg = 8'h39;
         4'hD: seg = 8'h5E;
         4'hE: seg = 8'h79;
         4'hF: seg = 8'h71;
         default: seg = '0;
      endcase
      return seg;
   endfunction

endpackage

// File: rtl/core/sssc_digit_cell.sv
// ----------------------------------------------------------------------------
// sssc_digit_cell
// One digit of the conversion row: adjust, shift in from below, carry up.
// ----------------------------------------------------------------------------
module sssc_digit_cell (
   input  logic                          clock,
   input  logic                          clear,
   input  logic                          shift,
   input  sssc_pkg::func_type            mode,
   input  logic                          bit_in,
   output logic                          bit_out,
   input  logic                          live_in,
   output logic                          live_out,
   output logic [sssc_pkg::DIGIT_W-1:0]  digit
);
   import sssc_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adjusted;

   always_comb begin
      adjusted = digit_ff;
      if (mode == FUNC_DEC && digit_ff >= DIGIT_W'(5)) begin
         adjusted = digit_ff + DIGIT_W'(3);
      end
      case (mode)
         FUNC_BIN: begin
            bit_out  = digit_ff[0];
            digit_in = {{(DIGIT_W-1){1'b0}}, bit_in};
         end
         default: begin
            bit_out  = adjusted[DIGIT_W-1];
            digit_in = {adjusted[DIGIT_W-2:0], bit_in};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         digit_ff <= '0;
      end else if (shift) begin
         digit_ff <= digit_in;
      end
   end

   assign live_out = live_in | (digit_ff != '0);
   assign digit    = digit_ff;

endmodule

// File: rtl/core/sssc_convert.sv
// ----------------------------------------------------------------------------
// sssc_convert
// Row of digit cells fed one value bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module sssc_convert #(
   parameter int DIGIT_COUNT = sssc_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  sssc_pkg::func_type            mode,
   input  logic [sssc_pkg::VALUE_W-1:0]  value,
   output sssc_pkg::conv_status_type     status,
   output logic [sssc_pkg::DIGIT_W-1:0]  digit [DIGIT_COUNT],
   output logic [DIGIT_COUNT-1:0]        live
);
   import sssc_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   func_type           mode_ff;
   logic               overflow_ff, overflow_in;

   logic [DIGIT_COUNT:0] bit_chain;
   logic [DIGIT_COUNT:0] live_chain;

   assign bit_chain[0]           = value_ff[VALUE_W-1];
   assign live_chain[DIGIT_COUNT] = overflow_ff;

   for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
      sssc_digit_cell u_cell (
         .clock    (clock),
         .clear    (load),
         .shift    (busy_ff),
         .mode     (mode_ff),
         .bit_in   (bit_chain[g]),
         .bit_out  (bit_chain[g+1]),
         .live_in  (live_chain[g+1]),
         .live_out (live_chain[g]),
         .digit    (digit[g])
      );
   end

   assign live = live_chain[DIGIT_COUNT-1:0];

   always_comb begin
      value_in    = value_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      overflow_in = overflow_ff;
      if (load) begin
         value_in    = value;
         count_in    = '0;
         busy_in     = 1'b1;
         overflow_in = 1'b0;
      end else if (busy_ff) begin
         value_in    = value_ff << 1;
         count_in    = count_ff + COUNT_W'(1);
         overflow_in = overflow_ff | bit_chain[DIGIT_COUNT];
         if (count_ff == COUNT_W'(CONV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      value_ff    <= value_in;
      overflow_ff <= overflow_in;
      if (load) begin
         mode_ff <= mode;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/core/seven_segment_scan_controller.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_controller
// Multiplexed seven-segment driver: print converts a value to digits through
// a row of digit cells, tick scans one digit out with an optional running dot.
//
//   channel   ports                                  handshake
//   request   req_func, req_value                    start high, busy low
//   response  rsp_digit_select, rsp_segments         rsp_strobe, one cycle
//   csr       psel penable pwrite paddr pwdata ...   APB write, pready high
//
// Tick: its beat strobes in the cycle after the tick is accepted.
// Print: busy lasts through 32 single-bit shifts through the cell row and then
// the write of the digit store.
// Reset is synchronous and clears the sequencing, scan and dot state and the digit store.
// The response side has no back-pressure; beats are never held.
// ----------------------------------------------------------------------------
`include "seven_segment_scan_controller_defines.svh"

module seven_segment_scan_controller #(
   parameter int DIGIT_COUNT = sssc_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sssc_pkg::FUNC_W-1:0]       req_func,
   input  logic [sssc_pkg::VALUE_W-1:0]      req_value,
   output logic                              rsp_strobe,
   output logic [sssc_pkg::SEL_W-1:0]        rsp_digit_select,
   output logic [sssc_pkg::SEG_W-1:0]        rsp_segments,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sssc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sssc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sssc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import sssc_pkg::*;

   localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   func_type           func;
   logic               accept, tick, print;
   conv_status_type    conv_status;
   logic [DIGIT_W-1:0] conv_digit [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] conv_live;

   logic [SEG_W-1:0]       store_ff [DIGIT_COUNT];
   logic [POS_W-1:0]       scan_ff, scan_in;
   logic [DIGIT_COUNT-1:0] dot_onehot_ff, dot_onehot_in;
   logic [DOT_DIV_W-1:0]   dot_div_ff, dot_div_in;
   logic                   dots_en_ff;
   logic                   strobe_ff;
   logic [SEL_W-1:0]       sel_ff, sel_in;
   logic [SEG_W-1:0]       seg_ff, seg_in;
   logic                   csr_write;

   assign func   = func_type'(req_func);
   assign busy   = conv_status.busy | conv_status.done;
   assign accept = start & ~busy;
   assign tick   = accept & (func == FUNC_TICK);
   assign print  = accept & (func != FUNC_TICK);

   sssc_convert #(.DIGIT_COUNT(DIGIT_COUNT)) u_convert (
      .clock  (clock),
      .reset  (reset),
      .load   (print),
      .mode   (func),
      .value  (req_value),
      .status (conv_status),
      .digit  (conv_digit),
      .live   (conv_live)
   );

   // advance scan and dot
   always_comb begin
      scan_in       = scan_ff;
      dot_onehot_in = dot_onehot_ff;
      dot_div_in    = dot_div_ff;
      if (tick) begin
         scan_in = (scan_ff == POS_W'(DIGIT_COUNT - 1)) ? '0 : scan_ff + POS_W'(1);
         if (dots_en_ff) begin
            dot_div_in = dot_div_ff + DOT_DIV_W'(1);
            if (dot_div_in == '0) begin
               dot_onehot_in = (dot_onehot_ff << 1) | (dot_onehot_ff >> (DIGIT_COUNT - 1));
            end
         end
      end
      for (int i = 0; i < SEL_W; i++) begin
         sel_in[i] = (32'(scan_in) == i);
      end
      seg_in = store_ff[scan_in];
      if (dots_en_ff && dot_onehot_in[scan_in]) begin
         seg_in[SEG_W-1] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         dot_onehot_ff <= DIGIT_COUNT'(1);
         dot_div_ff    <= '0;
         strobe_ff     <= 1'b0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         scan_ff       <= scan_in;
         dot_onehot_ff <= dot_onehot_in;
         dot_div_ff    <= dot_div_in;
         strobe_ff     <= tick;
         if (conv_status.done) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               store_ff[i] <= (i == 0 || conv_live[i]) ? glyph(conv_digit[i]) : '0;
            end
         end
      end
      if (tick) begin
         sel_ff <= sel_in;
         seg_ff <= seg_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_digit_select = sel_ff;
   assign rsp_segments     = seg_ff;

   // csr
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dots_en_ff <= 1'b0;
      end else if (csr_write && paddr[CSR_ADDR_W-1] == REG_DOTS_ENABLE) begin
         dots_en_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == REG_DOTS_ENABLE) ?
                   {{(CSR_DATA_W-1){1'b0}}, dots_en_ff} : '0;

   `SSSC_ASSERT(a_strobe_after_tick, rsp_strobe |-> $past(start && !busy && req_func == FUNC_TICK), "response beat without a tick")
   `SSSC_ASSERT(a_select_onehot, rsp_strobe |-> $onehot0(rsp_digit_select), "digit select not one-hot")
   `SSSC_ASSERT(a_dot_onehot, $onehot(dot_onehot_ff), "dot position lost")
   `SSSC_ASSERT_NEXT(a_print_busy, (start && !busy && req_func != FUNC_TICK), busy, "print accepted without busy")

endmodule
